// File: hw/rtl/mec_pkg.sv
// Shared types and constants for the magnetometer hard/soft-iron corrector.
// Holds the channel payload structs, register indexes and fixed-point widths.
// No dependencies; imported by every module of the block.
`default_nettype none

package mec_pkg;

  // Fixed-point widths
  localparam int unsigned RAW_W   = 16;  // raw sample, signed counts
  localparam int unsigned BIAS_W  = 20;  // hard-iron bias, Q16.4
  localparam int unsigned CEN_W   = 21;  // centred value, Q17.4
  localparam int unsigned COEF_W  = 18;  // soft-iron coefficient, Q4.14
  localparam int unsigned ROW_W   = 3 * COEF_W;
  localparam int unsigned PROD_W  = COEF_W + CEN_W;   // Q.18 product
  localparam int unsigned SUM_W   = PROD_W + 2;       // three-term row sum
  localparam int unsigned FRAC_DROP = 14;             // Q.18 -> Q.4
  localparam int unsigned RND_W   = SUM_W - FRAC_DROP;
  localparam int unsigned CAL_W   = 24;               // result, Q20.4
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = ROW_W;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_0  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_2  = 3'd5;

  // Reset values: zero bias, identity matrix
  localparam logic [ROW_W-1:0] ROW_0_RST = 54'd16384;
  localparam logic [ROW_W-1:0] ROW_1_RST = 54'd4294967296;
  localparam logic [ROW_W-1:0] ROW_2_RST = 54'd1125899906842624;

  typedef logic signed [BIAS_W-1:0] bias_t;
  typedef logic signed [CEN_W-1:0]  cen_t;
  typedef logic [ROW_W-1:0]         row_t;

  // Input payload
  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } in_t;

  // Result payload
  typedef struct packed {
    logic signed [CAL_W-1:0] cal_x;
    logic signed [CAL_W-1:0] cal_y;
    logic signed [CAL_W-1:0] cal_z;
    logic                    saturated;
  } out_t;

  // One row's rounded, clipped value and its clip flag
  typedef struct packed {
    logic signed [CAL_W-1:0] val;
    logic                    sat;
  } row_res_t;

  // Configuration held for the datapath
  typedef struct packed {
    bias_t bias_x;
    bias_t bias_y;
    bias_t bias_z;
    row_t  row_0;
    row_t  row_1;
    row_t  row_2;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/mec_cfg_regs.sv
// Configuration register file: three hard-iron biases and three matrix rows.
// Depends on mec_pkg for indexes, widths and reset values.
`default_nettype none

module mec_cfg_regs
  import mec_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  // Write decode; indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bias_x <= '0;
      cfg_r.bias_y <= '0;
      cfg_r.bias_z <= '0;
      cfg_r.row_0  <= ROW_0_RST;
      cfg_r.row_1  <= ROW_1_RST;
      cfg_r.row_2  <= ROW_2_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIAS_X: cfg_r.bias_x <= cfg_wdata[BIAS_W-1:0];
        CFG_BIAS_Y: cfg_r.bias_y <= cfg_wdata[BIAS_W-1:0];
        CFG_BIAS_Z: cfg_r.bias_z <= cfg_wdata[BIAS_W-1:0];
        CFG_ROW_0:  cfg_r.row_0  <= cfg_wdata[ROW_W-1:0];
        CFG_ROW_1:  cfg_r.row_1  <= cfg_wdata[ROW_W-1:0];
        CFG_ROW_2:  cfg_r.row_2  <= cfg_wdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hw/rtl/mec_row.sv
// One row of the soft-iron matrix: three registered products, then sum,
// round to Q.4 (ties up) and clip to 24 bits. Depends on mec_pkg.
`default_nettype none

module mec_row
  import mec_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  wire cen_t cen_x,
  input  wire cen_t cen_y,
  input  wire cen_t cen_z,
  input  wire row_t coefs,
  output row_res_t  res
);

  localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (FRAC_DROP - 1);
  localparam logic signed [RND_W-1:0] CAL_MAX  = RND_W'(8388607);
  localparam logic signed [RND_W-1:0] CAL_MIN  = -RND_W'(8388608);

  logic signed [COEF_W-1:0] coef_0, coef_1, coef_2;
  logic signed [PROD_W-1:0] prod_0_r, prod_1_r, prod_2_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_rnd;
  logic signed [RND_W-1:0]  q4;

  // Unpack the row: column 0 in the low bits
  assign coef_0 = signed'(coefs[COEF_W-1:0]);
  assign coef_1 = signed'(coefs[2*COEF_W-1:COEF_W]);
  assign coef_2 = signed'(coefs[3*COEF_W-1:2*COEF_W]);

  // Product register
  always_ff @(posedge clk) begin
    if (en) begin
      prod_0_r <= PROD_W'(coef_0 * cen_x);
      prod_1_r <= PROD_W'(coef_1 * cen_y);
      prod_2_r <= PROD_W'(coef_2 * cen_z);
    end
  end

  // Sum, round half up, drop 14 fraction bits
  assign sum     = SUM_W'(prod_0_r) + SUM_W'(prod_1_r) + SUM_W'(prod_2_r);
  assign sum_rnd = sum + HALF_LSB;
  assign q4      = RND_W'(sum_rnd >>> FRAC_DROP);

  // Clip to the Q20.4 range
  always_comb begin
    if (q4 > CAL_MAX) begin
      res.val = CAL_MAX[CAL_W-1:0];
      res.sat = 1'b1;
    end else if (q4 < CAL_MIN) begin
      res.val = CAL_MIN[CAL_W-1:0];
      res.sat = 1'b1;
    end else begin
      res.val = q4[CAL_W-1:0];
      res.sat = 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/magnetometer_ellipsoid_correction.sv
// Magnetometer hard-iron / soft-iron corrector, top level.
// Depends on mec_pkg, mec_cfg_regs and mec_row.
//
// Input channel (in_valid / in_stall / in_data) carries one raw x/y/z sample
// of signed 16-bit counts per transfer. Result channel (out_valid /
// out_stall / out_data) carries the corrected vector in signed Q20.4 with a
// flag set when any axis was clipped. Every sample gives exactly one result.
// The bias registers and matrix rows are written through cfg_we, cfg_index
// and cfg_wdata, by the user only while the block is empty (not enforced).
//
// Three register stages: input register, product register, result register.
// out_valid rises once a sample has passed all three registers. One sample
// is taken every cycle while out_stall stays low, since each stage loads
// whenever the stage after it is empty or moving.
// A stalled result holds in the output register while earlier stages keep
// filling; in_stall rises only once all three stages hold a sample.
// Synchronous reset empties the pipeline, zeroes the biases and loads the
// identity matrix.
`default_nettype none

module magnetometer_ellipsoid_correction
  import mec_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // sample channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg;
  in_t      in_r;
  out_t     out_r, out_nxt;
  logic     in_vld_r, prod_vld_r, out_vld_r;
  logic     in_vld_nxt, prod_vld_nxt, out_vld_nxt;
  logic     in_xfer, prod_en, out_en;
  cen_t     cen_x, cen_y, cen_z;
  row_res_t res_x, res_y, res_z;

  mec_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Pipeline advance: a stage loads when the one after it is empty or moving
  assign out_en   = prod_vld_r && (!out_vld_r || !out_stall);
  assign prod_en  = in_vld_r && (!prod_vld_r || out_en);
  assign in_stall = in_vld_r && !prod_en;
  assign in_xfer  = in_valid && !in_stall;

  assign in_vld_nxt   = in_xfer || (in_vld_r && !prod_en);
  assign prod_vld_nxt = prod_en || (prod_vld_r && !out_en);
  assign out_vld_nxt  = out_en || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      in_vld_r   <= in_vld_nxt;
      prod_vld_r <= prod_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r <= in_data;
    end
  end

  // Bring samples to Q.4 and remove the hard-iron bias
  assign cen_x = CEN_W'(signed'({in_r.raw_x, 4'b0000})) - CEN_W'(cfg.bias_x);
  assign cen_y = CEN_W'(signed'({in_r.raw_y, 4'b0000})) - CEN_W'(cfg.bias_y);
  assign cen_z = CEN_W'(signed'({in_r.raw_z, 4'b0000})) - CEN_W'(cfg.bias_z);

  // Soft-iron matrix, one unit per output axis
  mec_row u_row_x (
    .clk   (clk),
    .en    (prod_en),
    .cen_x (cen_x),
    .cen_y (cen_y),
    .cen_z (cen_z),
    .coefs (cfg.row_0),
    .res   (res_x)
  );

  mec_row u_row_y (
    .clk   (clk),
    .en    (prod_en),
    .cen_x (cen_x),
    .cen_y (cen_y),
    .cen_z (cen_z),
    .coefs (cfg.row_1),
    .res   (res_y)
  );

  mec_row u_row_z (
    .clk   (clk),
    .en    (prod_en),
    .cen_x (cen_x),
    .cen_y (cen_y),
    .cen_z (cen_z),
    .coefs (cfg.row_2),
    .res   (res_z)
  );

  // Result register
  always_comb begin
    out_nxt.cal_x     = res_x.val;
    out_nxt.cal_y     = res_y.val;
    out_nxt.cal_z     = res_z.val;
    out_nxt.saturated = res_x.sat || res_y.sat || res_z.sat;
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
